FILE: rtl/blt_pkg.sv
// Shared types and constants for the beacon link loss table.
`default_nettype none

package blt_pkg;

    localparam int ID_W       = 32;
    localparam int SEQ_W      = 31;
    localparam int FRAC_OUT_W = 16;
    localparam int DUP_W      = 32;

    localparam logic [SEQ_W-1:0] SEQ_MAX = {SEQ_W{1'b1}};

    typedef enum logic [1:0] {
        ST_NEW  = 2'd0,
        ST_UPD  = 2'd1,
        ST_DUP  = 2'd2,
        ST_FULL = 2'd3
    } t_status;

    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [SEQ_W-1:0] first_seq;
        logic [SEQ_W-1:0] last_seq;
        logic [SEQ_W-1:0] recv_count;
    } t_entry;

endpackage

`default_nettype wire

FILE: rtl/blt_frac_div.sv
// Bit-serial restoring divider for the loss fraction lost * 2^FRACTION_BITS / span.
`default_nettype none

module blt_frac_div #(
    parameter int FRACTION_BITS = 16
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_start,
    input  wire logic [blt_pkg::SEQ_W-1:0] i_lost,
    input  wire logic [blt_pkg::SEQ_W:0]   i_span,
    output logic                           o_done,
    output logic [((FRACTION_BITS > blt_pkg::FRAC_OUT_W) ?
                   FRACTION_BITS : blt_pkg::FRAC_OUT_W)-1:0] o_quot
);

    localparam int QW = (FRACTION_BITS > blt_pkg::FRAC_OUT_W) ?
                        FRACTION_BITS : blt_pkg::FRAC_OUT_W;
    localparam int CW = $clog2(FRACTION_BITS + 1);
    localparam int RW = blt_pkg::SEQ_W + 1;

    logic [CW-1:0] r_cnt;
    logic          r_done;
    logic [RW-1:0] r_rem;
    logic [RW-1:0] r_span;
    logic [QW-1:0] r_quot;

    logic [RW:0]   sh;
    logic          ge;
    logic [RW:0]   diff;

    // Remainder stays below span, so one shifted compare and subtract per bit.
    always_comb begin
        sh   = {r_rem, 1'b0};
        diff = sh - {1'b0, r_span};
        ge   = (sh >= {1'b0, r_span});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_cnt  <= CW'(FRACTION_BITS);
            r_done <= 1'b0;
        end else if (r_cnt != '0) begin
            r_cnt  <= r_cnt - CW'(1);
            r_done <= (r_cnt == CW'(1));
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= {1'b0, i_lost};
            r_span <= i_span;
            r_quot <= '0;
        end else if (r_cnt != '0) begin
            r_rem  <= ge ? diff[RW-1:0] : sh[RW-1:0];
            r_quot <= {r_quot[QW-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

`default_nettype wire

FILE: rtl/beacon_link_loss_table.sv
// Top level of the beacon link loss table: neighbour search, update and loss report.
//
// Channel   Direction  Handshake                      Payload
// -------   ---------  -----------------------------  ---------------------------------
// beacon    in         start high and busy low        i_sender_id, i_seq_number
// result    out        o_result_valid, one cycle      o_status, o_neighbour_id,
//                                                     o_received_count, o_lost_count,
//                                                     o_loss_fraction, o_duplicate_total
//
// Transactions: one at a time. The neighbour search reads the entry memory one
// entry a cycle and stops at the first hit. A hit then passes through the update,
// span and lost states and the bit-serial divider before the result is out.
// Reset: synchronous, clears the valid bits, the duplicate counter and control state;
// the entry memory needs no clearing pass, as invalid entries are never used.
// Stalls: none; the result strobe lasts one cycle and the receiver cannot hold it off.
`default_nettype none

module beacon_link_loss_table #(
    parameter int TABLE_ENTRIES = 16,
    parameter int FRACTION_BITS = 16
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic [blt_pkg::ID_W-1:0]       i_sender_id,
    input  wire logic [blt_pkg::SEQ_W-1:0]      i_seq_number,
    output logic                                o_result_valid,
    output logic [1:0]                          o_status,
    output logic [blt_pkg::ID_W-1:0]            o_neighbour_id,
    output logic [blt_pkg::SEQ_W-1:0]           o_received_count,
    output logic [blt_pkg::SEQ_W-1:0]           o_lost_count,
    output logic [blt_pkg::FRAC_OUT_W-1:0]      o_loss_fraction,
    output logic [blt_pkg::DUP_W-1:0]           o_duplicate_total
);

    localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW = $clog2(TABLE_ENTRIES + 1);
    localparam int QW = (FRACTION_BITS > blt_pkg::FRAC_OUT_W) ?
                        FRACTION_BITS : blt_pkg::FRAC_OUT_W;
    localparam int SW = blt_pkg::SEQ_W + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_UPD,
        S_SPAN,
        S_LOST,
        S_DIV
    } t_state;

    t_state                         r_state;

    // Current transaction
    logic [blt_pkg::ID_W-1:0]       r_id;
    logic [blt_pkg::SEQ_W-1:0]      r_seq;

    // Search pointers
    logic [CW-1:0]                  r_idx;
    logic                           r_cmp_pend;
    logic [AW-1:0]                  r_cmp_idx;
    logic                           r_free_found;
    logic [AW-1:0]                  r_free_idx;
    logic [AW-1:0]                  r_hit_idx;

    // Table state
    logic [TABLE_ENTRIES-1:0]       r_valid;
    logic [blt_pkg::DUP_W-1:0]      r_dup_cnt;
    blt_pkg::t_entry                r_mem [TABLE_ENTRIES];
    blt_pkg::t_entry                r_rd_data;

    // Working copy of the hit entry and loss arithmetic
    blt_pkg::t_entry                r_entry;
    blt_pkg::t_status               r_status;
    logic [SW-1:0]                  r_span;
    logic [blt_pkg::SEQ_W-1:0]      r_lost;

    // Result registers
    logic                           r_res_valid;
    blt_pkg::t_status               r_out_status;
    logic [blt_pkg::ID_W-1:0]       r_out_id;
    logic [blt_pkg::SEQ_W-1:0]      r_out_rc;
    logic [blt_pkg::SEQ_W-1:0]      r_out_lost;
    logic [blt_pkg::FRAC_OUT_W-1:0] r_out_frac;
    logic [blt_pkg::DUP_W-1:0]      r_out_dup;

    // Memory port controls
    logic                           mem_we;
    logic [AW-1:0]                  mem_wa;
    blt_pkg::t_entry                mem_wd;
    logic [AW-1:0]                  mem_ra;

    // Search and update decode
    logic                           idx_in_range;
    logic                           cmp_hit;
    logic                           cmp_free;
    logic                           scan_done;
    logic                           is_dup;
    logic [blt_pkg::SEQ_W-1:0]      rc_inc;
    blt_pkg::t_entry                upd_entry;
    logic [SW-1:0]                  rc_wide;
    logic [SW-1:0]                  lost_wide;

    // Divider
    logic                           div_start;
    logic                           div_done;
    logic [QW-1:0]                  div_quot;

    always_comb begin
        idx_in_range = (r_idx < CW'(TABLE_ENTRIES));
        cmp_hit      = r_cmp_pend && r_valid[r_cmp_idx] && (r_rd_data.id == r_id);
        cmp_free     = r_cmp_pend && !r_valid[r_cmp_idx] && !r_free_found;
        scan_done    = !r_cmp_pend && !idx_in_range;

        is_dup       = (r_seq <= r_entry.last_seq);
        rc_inc       = (r_entry.recv_count == blt_pkg::SEQ_MAX) ?
                       r_entry.recv_count : r_entry.recv_count + blt_pkg::SEQ_W'(1);
        upd_entry            = r_entry;
        upd_entry.last_seq   = r_seq;
        upd_entry.recv_count = rc_inc;

        rc_wide   = {1'b0, r_entry.recv_count};
        lost_wide = (rc_wide < r_span) ? (r_span - rc_wide) : '0;

        mem_ra = r_idx[AW-1:0];
        mem_we = 1'b0;
        mem_wa = r_hit_idx;
        mem_wd = upd_entry;
        if (r_state == S_SCAN && scan_done && r_free_found) begin
            // Claim the lowest free slot for a new neighbour
            mem_we = 1'b1;
            mem_wa = r_free_idx;
            mem_wd = '{id: r_id, first_seq: r_seq, last_seq: r_seq,
                       recv_count: blt_pkg::SEQ_W'(1)};
        end else if (r_state == S_UPD && !is_dup) begin
            mem_we = 1'b1;
        end

        div_start = (r_state == S_LOST);
    end

    // Entry memory: one write port, one registered read port. The read data is used only
    // in the search, writes come only at its end or in the update state, so they never meet.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rd_data <= r_mem[mem_ra];
    end

    blt_frac_div #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_lost  (lost_wide[blt_pkg::SEQ_W-1:0]),
        .i_span  (r_span),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_valid      <= '0;
            r_dup_cnt    <= '0;
            r_res_valid  <= 1'b0;
            r_cmp_pend   <= 1'b0;
            r_free_found <= 1'b0;
        end else begin
            r_res_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        // Latch the beacon and start the search from entry zero
                        r_id         <= i_sender_id;
                        r_seq        <= i_seq_number;
                        r_idx        <= '0;
                        r_cmp_pend   <= 1'b0;
                        r_free_found <= 1'b0;
                        r_state      <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    r_cmp_pend <= idx_in_range;
                    r_cmp_idx  <= r_idx[AW-1:0];
                    if (idx_in_range) begin
                        r_idx <= r_idx + CW'(1);
                    end
                    if (cmp_free) begin
                        r_free_found <= 1'b1;
                        r_free_idx   <= r_cmp_idx;
                    end
                    if (cmp_hit) begin
                        // First matching valid entry wins; stop the search
                        r_hit_idx  <= r_cmp_idx;
                        r_entry    <= r_rd_data;
                        r_cmp_pend <= 1'b0;
                        r_state    <= S_UPD;
                    end else if (scan_done) begin
                        r_out_id    <= r_id;
                        r_out_lost  <= '0;
                        r_out_frac  <= '0;
                        r_out_dup   <= r_dup_cnt;
                        r_res_valid <= 1'b1;
                        r_state     <= S_IDLE;
                        if (r_free_found) begin
                            r_valid[r_free_idx] <= 1'b1;
                            r_out_status        <= blt_pkg::ST_NEW;
                            r_out_rc            <= blt_pkg::SEQ_W'(1);
                        end else begin
                            r_out_status <= blt_pkg::ST_FULL;
                            r_out_rc     <= '0;
                        end
                    end
                end
                S_UPD: begin
                    if (is_dup) begin
                        // Drop the beacon, count it, report the entry as it stands
                        r_dup_cnt <= r_dup_cnt + blt_pkg::DUP_W'(1);
                        r_status  <= blt_pkg::ST_DUP;
                    end else begin
                        r_entry  <= upd_entry;
                        r_status <= blt_pkg::ST_UPD;
                    end
                    r_state <= S_SPAN;
                end
                S_SPAN: begin
                    // Last never falls below first, so span lies in 1 .. 2^31
                    r_span  <= {1'b0, r_entry.last_seq} - {1'b0, r_entry.first_seq}
                               + SW'(1);
                    r_state <= S_LOST;
                end
                S_LOST: begin
                    r_lost  <= lost_wide[blt_pkg::SEQ_W-1:0];
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (div_done) begin
                        r_out_status <= r_status;
                        r_out_id     <= r_id;
                        r_out_rc     <= r_entry.recv_count;
                        r_out_lost   <= r_lost;
                        r_out_frac   <= div_quot[blt_pkg::FRAC_OUT_W-1:0];
                        r_out_dup    <= r_dup_cnt;
                        r_res_valid  <= 1'b1;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy              = (r_state != S_IDLE);
    assign o_result_valid    = r_res_valid;
    assign o_status          = r_out_status;
    assign o_neighbour_id    = r_out_id;
    assign o_received_count  = r_out_rc;
    assign o_lost_count      = r_out_lost;
    assign o_loss_fraction   = r_out_frac;
    assign o_duplicate_total = r_out_dup;

    // An accepted beacon raises busy, which the block holds until its result is out
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after an accepted beacon");

    // A result strobe is a single-cycle pulse
    a_strobe_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_valid |=> !r_res_valid)
        else $error("result strobe held longer than one cycle");

    // A new entry reports one beacon and no loss
    a_new_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_res_valid && r_out_status == blt_pkg::ST_NEW) |->
        (r_out_rc == blt_pkg::SEQ_W'(1) && r_out_lost == '0 && r_out_frac == '0))
        else $error("new entry reported with loss");

    // Table full is reported only when every entry is in use
    a_full_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_res_valid && r_out_status == blt_pkg::ST_FULL) |-> (&r_valid))
        else $error("table full reported with a free entry");

    // A nonzero fraction needs a nonzero lost count
    a_frac_lost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_res_valid && r_out_frac != '0) |-> (r_out_lost != '0))
        else $error("loss fraction without lost beacons");

endmodule

`default_nettype wire
